@@ hw/rtl/audio_peak_level_meter_core_macros.svh @@
// Assertion macros used by the peak level meter top level.
`ifndef AUDIO_PEAK_LEVEL_METER_CORE_MACROS_SVH
`define AUDIO_PEAK_LEVEL_METER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/plm_pkg.sv @@
// Package of the peak level meter: register map, constants, constant functions.
`timescale 1ns / 1ps
package plm_pkg;

   localparam int CHANNELS_DEF = 2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_ACTIVE  = 3'd0;
   localparam logic [2:0] REG_DBMODE  = 3'd1;
   localparam logic [2:0] REG_DBRANGE = 3'd2;
   localparam logic [2:0] REG_DECAYEN = 3'd3;
   localparam logic [2:0] REG_DECAYRT = 3'd4;
   localparam logic [2:0] REG_SRATE   = 3'd5;

   // register reset values
   localparam logic [5:0]  RST_ACTIVE  = 6'd2;
   localparam logic        RST_DBMODE  = 1'b1;
   localparam logic [6:0]  RST_DBRANGE = 7'd60;
   localparam logic        RST_DECAYEN = 1'b1;
   localparam logic [7:0]  RST_DECAYRT = 8'd60;
   localparam logic [17:0] RST_SRATE   = 18'd44100;

   // 20*log10(2) in Q16, and 1/(20*log10(e)*ln 2) scaling in Q24
   localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
   localparam logic [21:0] LOG2_PER_DB = 22'd2786635;

   // integer square root, bit-pair method
   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      int i;
      n = n_in;
      res = 64'd0;
      bitv = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // log2 in Q16, integer part in the upper bits
   function automatic logic [19:0] log2_q16(input logic [31:0] x);
      logic [4:0]  n;
      logic [15:0] frac;
      logic [63:0] m;
      int i;
      n = 5'd0;
      frac = 16'd0;
      for (i = 0; i < 30; i++) begin
         if ((x >> (n + 5'd1)) != 32'd0) n = n + 5'd1;
      end
      m = 64'(x) << (5'd30 - n);
      for (i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 16'd1;
         end
      end
      return {n[3:0], frac};
   endfunction

   // Q30 factors 2^(-2^-(k+1)) by the square root chain
   function automatic logic [15:0][29:0] decay_consts();
      logic [15:0][29:0] r;
      logic [63:0] c;
      int k;
      c = isqrt64(64'd1 << 59);
      for (k = 0; k < 16; k++) begin
         r[k] = c[29:0];
         c = isqrt64(c << 30);
      end
      return r;
   endfunction

   localparam logic [19:0]       LOG2_FS = log2_q16(32'd32767);
   localparam logic [15:0][29:0] DECAY_C = decay_consts();

endpackage

@@ hw/rtl/audio_peak_level_meter_core.sv @@
// Top level of the peak level meter: registers, sequencer, datapath, state memory.
//
//  channel | dir | fields
//  req_    | in  | tdata sample, tuser channel, tlast end_of_block
//  rsp_    | out | tdata level, tuser bar_channel, tlast last_channel
//  csr_    | in  | APB registers at 4*index, six registers
//
// A word without block end takes a memory read, then a peak write-back. A block
// end adds a decay setup (a divide, then in linear mode the exponent and factor
// steps; none with decay off) and per channel a memory read, in dB mode with a
// nonzero peak the 16-step log2 squaring loop and, unless below the window, a
// divide by the 40-step serial divider. Synchronous reset clears control state
// and marks every memory entry as zero. Input is held off while a block end is
// processed; a waiting result stalls only the next channel write-back.
`timescale 1ns / 1ps
`include "audio_peak_level_meter_core_macros.svh"
module audio_peak_level_meter_core
   import plm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic [4:0]  req_tuser,   // [4:0] channel
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] level
   output logic [4:0]  rsp_tuser,   // [4:0] bar_channel
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [4:0] LAST_CH = 5'(CHANNELS - 1);

   typedef enum logic [13:0] {
      S_IDLE = 14'b00000000000001,
      S_PRD  = 14'b00000000000010,
      S_DK   = 14'b00000000000100,
      S_DKW  = 14'b00000000001000,
      S_LEXP = 14'b00000000010000,
      S_LFAC = 14'b00000000100000,
      S_CH   = 14'b00000001000000,
      S_CRD  = 14'b00000010000000,
      S_LOG  = 14'b00000100000000,
      S_ATT  = 14'b00001000000000,
      S_ATC  = 14'b00010000000000,
      S_VW   = 14'b00100000000000,
      S_MRG  = 14'b01000000000000,
      S_OUT  = 14'b10000000000000
   } state_type;

   // configuration registers
   logic [5:0]  act_ff, act_in;
   logic        dbm_ff, dbm_in;
   logic [6:0]  rng_ff, rng_in;
   logic        den_ff, den_in;
   logic [7:0]  rate_ff, rate_in;
   logic [17:0] sr_ff, sr_in;

   // sequencer and datapath registers
   state_type   state_ff, state_in;
   logic [15:0] smp_ff, smp_in;
   logic [4:0]  ch_ff, ch_in;
   logic        eob_ff, eob_in;
   logic [15:0] frame_ff, frame_in;
   logic [4:0]  j_ff, j_in;
   logic [3:0]  k_ff, k_in;
   logic [39:0] step_ff, step_in;
   logic [3:0]  ip_ff, ip_in;
   logic        izero_ff, izero_in;
   logic [15:0] f_ff, f_in;
   logic [30:0] fac_ff, fac_in;
   logic [31:0] m_ff, m_in;
   logic [3:0]  n_ff, n_in;
   logic [15:0] frac_ff, frac_in;
   logic [15:0] att_ff, att_in;
   logic [15:0] bar_ff, bar_in;
   logic [15:0] val_ff, val_in;
   logic [15:0] nbar_ff, nbar_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic [4:0]  rsp_ch_ff, rsp_ch_in;
   logic        rsp_last_ff, rsp_last_in;

   // memory and divider hookup
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [30:0]   mem_wd, mem_rd;
   logic          div_start, div_busy, div_done;
   logic [39:0]   div_num, div_quo;
   logic [24:0]   div_den;

   // effective register values
   logic [5:0]  act_eff;
   logic [4:0]  act_m1;
   logic [6:0]  rng_eff;
   logic [17:0] sr_eff;
   logic        csr_wr;

   // datapath terms
   logic [14:0] rd_peak;
   logic [15:0] rd_bar;
   logic [23:0] rf;
   logic [39:0] db_num, lin_num, val_db_num;
   logic [15:0] val_lin;
   logic [24:0] sr_rng;
   logic [53:0] e_prod;
   logic [60:0] fac_prod;
   logic [61:0] sq;
   logic [31:0] sq_t;
   logic [3:0]  nbit;
   logic [31:0] norm_m;
   logic [19:0] lp, ldiff;
   logic [39:0] att_prod;
   logic [14:0] r_q, ratt;
   logic [46:0] bar_fac;
   logic [15:0] lin_dec, db_dec, dec;
   logic        ch_ok, out_go;

   assign csr_wr  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign act_eff = (act_ff == 6'd0) ? 6'd1 : ((act_ff > 6'd32) ? 6'd32 : act_ff);
   assign act_m1  = 5'(act_eff - 6'd1);
   assign rng_eff = (rng_ff == 7'd0) ? 7'd1 : rng_ff;
   assign sr_eff  = (sr_ff == 18'd0) ? 18'd1 : sr_ff;

   assign rd_peak = mem_rd[30:16];
   assign rd_bar  = mem_rd[15:0];

   // decay setup terms
   assign rf      = 24'(rate_ff) * 24'(frame_ff);
   assign db_num  = {rf, 16'd0} - 40'(rf);
   assign lin_num = 40'({rf, 8'd0});
   assign sr_rng  = 25'(sr_eff) * 25'(rng_eff);
   assign e_prod  = 54'(div_quo[31:0]) * 54'(LOG2_PER_DB);
   assign fac_prod = 61'(fac_ff) * 61'(DECAY_C[k_ff]);

   // log2 normalize and squaring step
   always_comb begin
      nbit = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (rd_peak[i]) nbit = 4'(i);
      end
   end
   assign norm_m = 32'(rd_peak) << (5'd30 - {1'b0, nbit});
   assign sq     = 62'(m_ff[30:0]) * 62'(m_ff[30:0]);
   assign sq_t   = sq[61:30];

   // attenuation and dB window value
   assign lp       = {n_ff, frac_ff};
   assign ldiff    = (LOG2_FS > lp) ? (LOG2_FS - lp) : 20'd0;
   assign att_prod = 40'(ldiff) * 40'(DB_PER_LOG2) + (40'd1 << 23);
   assign r_q      = {rng_eff, 8'd0};
   assign ratt     = r_q - att_ff[14:0];
   assign val_db_num  = {8'd0, ratt, 16'd0} - 40'(ratt) + 40'(r_q >> 1);
   // rounded peak * 65535 / 32767 reduces to 2 * peak, plus one from half scale up
   assign val_lin  = {rd_peak, 1'b0} + 16'(rd_peak[14]);

   // decayed bar
   assign bar_fac = 47'(bar_ff) * 47'(fac_ff);
   assign lin_dec = izero_ff ? 16'd0 : (bar_fac[45:30] >> ip_ff);
   assign db_dec  = (step_ff >= 40'(bar_ff)) ? 16'd0 : (bar_ff - step_ff[15:0]);
   assign dec     = dbm_ff ? db_dec : lin_dec;

   assign ch_ok  = ({1'b0, ch_ff} < 6'(CHANNELS)) && (ch_ff <= act_m1);
   assign out_go = !rsp_valid_ff || rsp_tready;

   // register writes
   always_comb begin
      act_in  = act_ff;
      dbm_in  = dbm_ff;
      rng_in  = rng_ff;
      den_in  = den_ff;
      rate_in = rate_ff;
      sr_in   = sr_ff;
      if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_ACTIVE:  act_in  = csr_pwdata[5:0];
            REG_DBMODE:  dbm_in  = csr_pwdata[0];
            REG_DBRANGE: rng_in  = csr_pwdata[6:0];
            REG_DECAYEN: den_in  = csr_pwdata[0];
            REG_DECAYRT: rate_in = csr_pwdata[7:0];
            REG_SRATE:   sr_in   = csr_pwdata[17:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[4:2])
         REG_ACTIVE:  csr_prdata = 32'(act_ff);
         REG_DBMODE:  csr_prdata = 32'(dbm_ff);
         REG_DBRANGE: csr_prdata = 32'(rng_ff);
         REG_DECAYEN: csr_prdata = 32'(den_ff);
         REG_DECAYRT: csr_prdata = 32'(rate_ff);
         REG_SRATE:   csr_prdata = 32'(sr_ff);
         default:     csr_prdata = 32'd0;
      endcase
   end
   assign csr_pready = 1'b1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      smp_in = smp_ff;
      ch_in = ch_ff;
      eob_in = eob_ff;
      frame_in = frame_ff;
      j_in = j_ff;
      k_in = k_ff;
      step_in = step_ff;
      ip_in = ip_ff;
      izero_in = izero_ff;
      f_in = f_ff;
      fac_in = fac_ff;
      m_in = m_ff;
      n_in = n_ff;
      frac_in = frac_ff;
      att_in = att_ff;
      bar_in = bar_ff;
      val_in = val_ff;
      nbar_in = nbar_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_ch_in = rsp_ch_ff;
      rsp_last_in = rsp_last_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      mem_we = 1'b0;
      mem_wa = j_ff[AW-1:0];
      mem_wd = '0;
      mem_ra = j_ff[AW-1:0];
      req_tready = 1'b0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            mem_ra = req_tuser[AW-1:0];
            if (req_tvalid) begin
               smp_in = req_tdata;
               ch_in = req_tuser;
               eob_in = req_tlast;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            // peak update and frame count
            mem_wa = ch_ff[AW-1:0];
            mem_wd = {smp_ff[14:0], rd_bar};
            mem_we = ch_ok && !smp_ff[15] && (smp_ff[14:0] > rd_peak);
            if ((ch_ff == act_m1) && (frame_ff != 16'hFFFF)) frame_in = frame_ff + 16'd1;
            state_in = eob_ff ? S_DK : S_IDLE;
         end
         S_DK: begin
            j_in = 5'd0;
            if (!den_ff) begin
               state_in = S_CH;
            end else begin
               div_start = 1'b1;
               div_num = dbm_ff ? db_num : lin_num;
               div_den = dbm_ff ? sr_rng : 25'(sr_eff);
               state_in = S_DKW;
            end
         end
         S_DKW: begin
            if (div_done) begin
               step_in = div_quo;
               state_in = dbm_ff ? S_CH : S_LEXP;
            end
         end
         S_LEXP: begin
            izero_in = |e_prod[53:36];
            ip_in = e_prod[35:32];
            f_in = e_prod[31:16];
            fac_in = 31'd1 << 30;
            k_in = 4'd0;
            state_in = S_LFAC;
         end
         S_LFAC: begin
            if (f_ff[~k_ff]) fac_in = fac_prod[60:30];
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd15) state_in = S_CH;
         end
         S_CH: begin
            state_in = S_CRD;
         end
         S_CRD: begin
            bar_in = rd_bar;
            if (!dbm_ff) begin
               val_in = val_lin;
               state_in = S_MRG;
            end else if (rd_peak == 15'd0) begin
               val_in = 16'd0;
               state_in = S_MRG;
            end else begin
               m_in = norm_m;
               n_in = nbit;
               frac_in = 16'd0;
               k_in = 4'd0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            if (sq_t[31]) begin
               m_in = sq_t >> 1;
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               m_in = sq_t;
               frac_in = {frac_ff[14:0], 1'b0};
            end
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd15) state_in = S_ATT;
         end
         S_ATT: begin
            att_in = att_prod[39:24];
            state_in = S_ATC;
         end
         S_ATC: begin
            if (att_ff >= 16'(r_q)) begin
               val_in = 16'd0;
               state_in = S_MRG;
            end else begin
               div_start = 1'b1;
               div_num = val_db_num;
               div_den = 25'(r_q);
               state_in = S_VW;
            end
         end
         S_VW: begin
            if (div_done) begin
               val_in = div_quo[15:0];
               state_in = S_MRG;
            end
         end
         S_MRG: begin
            if (!den_ff) nbar_in = val_ff;
            else nbar_in = (val_ff > dec) ? val_ff : dec;
            state_in = S_OUT;
         end
         S_OUT: begin
            // write back, clear peak, hand the word out
            if (out_go) begin
               mem_we = 1'b1;
               mem_wd = {15'd0, nbar_ff};
               rsp_valid_in = 1'b1;
               rsp_data_in = nbar_ff;
               rsp_ch_in = j_ff;
               rsp_last_in = (j_ff == LAST_CH);
               if (j_ff == LAST_CH) begin
                  frame_in = 16'd0;
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + 5'd1;
                  state_in = S_CH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= RST_ACTIVE;
         dbm_ff <= RST_DBMODE;
         rng_ff <= RST_DBRANGE;
         den_ff <= RST_DECAYEN;
         rate_ff <= RST_DECAYRT;
         sr_ff <= RST_SRATE;
         state_ff <= S_IDLE;
         frame_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         dbm_ff <= dbm_in;
         rng_ff <= rng_in;
         den_ff <= den_in;
         rate_ff <= rate_in;
         sr_ff <= sr_in;
         state_ff <= state_in;
         frame_ff <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      ch_ff <= ch_in;
      eob_ff <= eob_in;
      j_ff <= j_in;
      k_ff <= k_in;
      step_ff <= step_in;
      ip_ff <= ip_in;
      izero_ff <= izero_in;
      f_ff <= f_in;
      fac_ff <= fac_in;
      m_ff <= m_in;
      n_ff <= n_in;
      frac_ff <= frac_in;
      att_ff <= att_in;
      bar_ff <= bar_in;
      val_ff <= val_in;
      nbar_ff <= nbar_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ch_ff <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   plm_mem #(.AW(AW), .W(31)) u_mem (
      .clock(clock),
      .reset(reset),
      .we(mem_we),
      .wa(mem_wa),
      .wd(mem_wd),
      .ra(mem_ra),
      .rd(mem_rd)
   );

   plm_div #(.NW(40), .DW(25)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .busy(div_busy),
      .done(div_done),
      .quo(div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ch_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PLM_ASSERT_SAME(a_ready_div_idle, clock, reset, req_tready, !div_busy, "input ready during divide")
   `PLM_ASSERT_SAME(a_last_is_top_ch, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == LAST_CH, "last word not on top channel")
   `PLM_ASSERT_NEXT(a_frame_cleared, clock, reset, (state_ff == S_OUT) && out_go && (j_ff == LAST_CH), (frame_ff == 16'd0) && (state_ff == S_IDLE), "frame count not cleared after block")

endmodule

@@ hw/rtl/plm_mem.sv @@
// Per-channel state memory {block peak, bar level}, registered read, valid bits for reset.
`timescale 1ns / 1ps
module plm_mem
   import plm_pkg::*;
#(
   parameter int AW = 1,
   parameter int W  = 31
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] wa,
   input  logic [W-1:0]  wd,
   input  logic [AW-1:0] ra,
   output logic [W-1:0]  rd
);
   localparam int DEPTH = 2 ** AW;

   logic [W-1:0]     mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [W-1:0]     rdata_ff;
   logic             rvld_ff;

   // entry becomes valid on its first write
   always_comb begin
      valid_in = valid_ff;
      if (we) valid_in[wa] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // array write and registered read
   always_ff @(posedge clock) begin
      if (we) mem_ff[wa] <= wd;
      rdata_ff <= mem_ff[ra];
      rvld_ff  <= valid_ff[ra];
   end

   assign rd = rvld_ff ? rdata_ff : '0;

endmodule

@@ hw/rtl/plm_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module plm_div
   import plm_pkg::*;
#(
   parameter int NW = 40,
   parameter int DW = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   assign trial = {r_ff, q_ff[NW-1]};

   // shift in a numerator bit, subtract when it fits
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DW'(trial - {1'b0, d_ff});
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial[DW-1:0];
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = q_ff;

endmodule

@@ tb/tb_audio_peak_level_meter_core.sv @@
// Self-checking testbench of the peak level meter: directed and random streams against a built-in predictor.
`timescale 1ns / 1ps
module tb_audio_peak_level_meter_core;
   import plm_pkg::*;

   localparam int NCH = 2;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [2:0] REG_UNUSED = 3'd6;

   typedef bit [63:0] u64_type;

   // one input word and one expected result word
   typedef struct {
      logic signed [15:0] sample;
      logic [4:0]         channel;
      logic               eob;
      bit                 hold;     // wait for every pending result before sending
   } sample_word_type;

   typedef struct {
      logic [4:0]  chan;
      logic [15:0] level;
      logic        last;
   } level_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] sample
   logic [4:0]  req_tuser = '0;    // [4:0] channel
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] level
   logic [4:0]  rsp_tuser;         // [4:0] bar_channel
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   audio_peak_level_meter_core #(.CHANNELS(NCH)) u_top (.*);

   always #6 clock = ~clock;

   // predictor copy of registers and meter state
   logic [5:0]  cfg_active = RST_ACTIVE;
   logic        cfg_dbmode = RST_DBMODE;
   logic [6:0]  cfg_range  = RST_DBRANGE;
   logic        cfg_decay  = RST_DECAYEN;
   logic [7:0]  cfg_rate   = RST_DECAYRT;
   logic [17:0] cfg_srate  = RST_SRATE;
   logic [14:0] peak_store [NCH];
   logic [15:0] bar_store [NCH];
   logic [15:0] frame_tally = '0;

   sample_word_type sample_q[$];
   level_word_type  level_q[$];
   sample_word_type cur_word;
   int n_sent = 0, n_acc = 0, n_err = 0, cycles = 0;
   int send_gap = 0, recv_stall = 0;
   bit calm = 1'b0;

   initial begin
      for (int j = 0; j < NCH; j++) begin
         peak_store[j] = '0;
         bar_store[j] = '0;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
      n_err++;
   endtask

   // ---------------- predictor ----------------
   function automatic u64_type int_sqrt(input u64_type n);
      u64_type res, b;
      res = 0;
      b = u64_type'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic u64_type log2_fix(input u64_type x);
      u64_type m, n, frac;
      n = 0;
      frac = 0;
      if (x == 0) return 0;
      while (n < 30 && (x >> (n + 1)) != 0) n++;
      m = x << (30 - n);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (u64_type'(1) << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (n << 16) | frac;
   endfunction

   function automatic u64_type peak_to_level(input u64_type pk);
      u64_type r, att, lf, lp;
      if (!cfg_dbmode) return (pk * 65535 + 16383) / 32767;
      if (pk == 0) return 0;
      r = u64_type'(cfg_range == 0 ? 7'd1 : cfg_range) << 8;
      lf = log2_fix(32767);
      lp = log2_fix(pk);
      att = (lf > lp) ? (((lf - lp) * 394566 + (u64_type'(1) << 23)) >> 24) : 0;
      if (att >= r) return 0;
      return ((r - att) * 65535 + r / 2) / r;
   endfunction

   function automatic u64_type scale_decay(input u64_type lvl, input u64_type frames,
                                           input u64_type sr);
      u64_type a, e, ip, factor, c, f;
      a = (u64_type'(cfg_rate) * frames << 8) / sr;
      e = (a * 2786635) >> 16;
      ip = e >> 16;
      f = e & 16'hFFFF;
      factor = u64_type'(1) << 30;
      if (ip >= 16) return 0;
      c = int_sqrt(u64_type'(1) << 59);
      for (int k = 0; k < 16; k++) begin
         if (f[15-k]) factor = (factor * c) >> 30;
         c = int_sqrt(c << 30);
      end
      return ((lvl * factor) >> 30) >> ip;
   endfunction

   function automatic int eff_active();
      if (cfg_active == 0) return 1;
      if (cfg_active > 32) return 32;
      return cfg_active;
   endfunction

   // update meter state for one accepted word and queue the levels it produces
   task automatic meter_update(input sample_word_type w);
      int act;
      u64_type sr, rng, val, lvl, dec, fall;
      level_word_type lw;
      act = eff_active();
      if (w.channel < NCH && w.channel < act && w.sample >= 0
          && 15'(w.sample) > peak_store[w.channel])
         peak_store[w.channel] = 15'(w.sample);
      if (w.channel == act - 1 && frame_tally != 16'hFFFF) frame_tally++;
      if (!w.eob) return;
      sr = (cfg_srate == 0) ? 1 : cfg_srate;
      rng = (cfg_range == 0) ? 1 : cfg_range;
      for (int j = 0; j < NCH; j++) begin
         lvl = bar_store[j];
         val = peak_to_level(peak_store[j]);
         if (cfg_decay) begin
            if (cfg_dbmode) begin
               fall = (u64_type'(cfg_rate) * frame_tally * 65535) / (sr * rng);
               dec = (fall >= lvl) ? 0 : lvl - fall;
            end else begin
               dec = scale_decay(lvl, frame_tally, sr);
            end
            lvl = (val > dec) ? val : dec;
         end else begin
            lvl = val;
         end
         bar_store[j] = 16'(lvl);
         peak_store[j] = '0;
         lw.chan = 5'(j);
         lw.level = bar_store[j];
         lw.last = (j == NCH - 1);
         level_q.push_back(lw);
      end
      frame_tally = '0;
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            meter_update(cur_word);
            n_acc++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_q.size() > 0 && !(sample_q[0].hold && level_q.size() > 0)) begin
               cur_word = sample_q.pop_front();
               req_tdata <= cur_word.sample;
               req_tuser <= cur_word.channel;
               req_tlast <= cur_word.eob;
               req_tvalid <= 1'b1;
               n_sent++;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if ($urandom_range(0, 299) == 0) calm = ~calm;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      level_word_type lw;
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (level_q.size() == 0) begin
               report_mismatch("unexpected level word, channel", rsp_tuser, -1);
            end else begin
               lw = level_q.pop_front();
               if (rsp_tuser !== lw.chan) report_mismatch("bar_channel", rsp_tuser, lw.chan);
               if (rsp_tdata !== lw.level) report_mismatch("level", rsp_tdata, lw.level);
               if (rsp_tlast !== lw.last) report_mismatch("last_channel", rsp_tlast, lw.last);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (!calm) begin
               if (r < 20) recv_stall = $urandom_range(1, 3);
               else if (r < 24) recv_stall = $urandom_range(10, 40);
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(input logic [2:0] idx, input int unsigned val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_pwdata <= $urandom;
      case (idx)
         REG_ACTIVE:  cfg_active = val[5:0];
         REG_DBMODE:  cfg_dbmode = val[0];
         REG_DBRANGE: cfg_range  = val[6:0];
         REG_DECAYEN: cfg_decay  = val[0];
         REG_DECAYRT: cfg_rate   = val[7:0];
         REG_SRATE:   cfg_srate  = val[17:0];
         default: ;
      endcase
   endtask

   // fields in the low bits, random junk above them
   task automatic set_meter(input int act, input int dbm, input int rng, input int den,
                            input int rate, input int sr);
      csr_write(REG_ACTIVE,  act  | ($urandom << 6));
      csr_write(REG_DBMODE,  dbm  | ($urandom << 1));
      csr_write(REG_DBRANGE, rng  | ($urandom << 7));
      csr_write(REG_DECAYEN, den  | ($urandom << 1));
      csr_write(REG_DECAYRT, rate | ($urandom << 8));
      csr_write(REG_SRATE,   sr   | ($urandom << 18));
   endtask

   task automatic push_word(input int s, input int ch, input bit eob, input bit hold = 0);
      sample_word_type w;
      w.sample = 16'(s);
      w.channel = 5'(ch);
      w.eob = eob;
      w.hold = hold;
      sample_q.push_back(w);
   endtask

   function automatic int rand_sample();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, 40);
         2: return 16'($urandom >> (16 + $urandom_range(0, 15)));
         default: return 32767 - $urandom_range(0, 300);
      endcase
   endfunction

   // well-formed blocks of whole frames, with some noise words mixed in
   task automatic fill_phase(input int n_words);
      int act, frames, start;
      start = sample_q.size();
      act = eff_active();
      while (sample_q.size() - start < n_words) begin
         if ($urandom_range(0, 99) < 15) begin
            push_word($urandom_range(0, 65535), $urandom_range(0, 31),
                      $urandom_range(0, 5) == 0);
         end else begin
            frames = (act > 4) ? 1 : $urandom_range(1, 4);
            for (int f = 0; f < frames; f++)
               for (int c = 0; c < act; c++)
                  push_word(rand_sample(), c, (f == frames - 1) && (c == act - 1));
         end
      end
   endtask

   task automatic drain();
      while (!(sample_q.size() == 0 && n_acc == n_sent && level_q.size() == 0))
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, dB mode with decay
      push_word(0, 0, 0);       push_word(0, 1, 1);        // zero peaks
      push_word(32767, 0, 0);   push_word(-32768, 1, 1);   // full scale and most negative
      push_word(-1, 0, 0);      push_word(1, 1, 1);
      push_word(100, 5, 0);     push_word(200, 31, 0);     // ignored channels
      push_word(300, 1, 1);
      push_word(32, 0, 0);      push_word(33, 1, 0);       // near bottom of window
      push_word(31, 0, 0);      push_word(30000, 1, 1);
      push_word(16384, 0, 0);   push_word(-2, 1, 0);
      push_word(8, 0, 0);       push_word(0, 1, 1);
      push_word(0, 0, 0);       push_word(0, 1, 1, 1);     // bars falling, after a pause
      drain();

      // linear display, scaled decay
      set_meter(2, 0, 60, 1, 60, 44100);
      fill_phase(45);
      push_word(32767, 0, 0, 1); push_word(12000, 1, 1);
      drain();
      // extremes: narrow window, fastest fall
      set_meter(1, 1, 1, 1, 255, 1);
      fill_phase(40);
      drain();
      // linear, shift exponent out of range
      set_meter(32, 0, 120, 1, 255, 1);
      fill_phase(40);
      drain();
      // zero active, range and sample rate registers act as one
      set_meter(0, 1, 0, 0, 0, 0);
      fill_phase(30);
      drain();
      // above 32 channels, widest window, no fall
      set_meter(63, 1, 127, 1, 0, 192000);
      fill_phase(35);
      drain();
      set_meter(3, 0, 7, 0, 128, 262143);
      fill_phase(30);
      drain();
      csr_write(REG_UNUSED, $urandom);
      csr_write(REG_UNUSED + 3'd1, $urandom);
      for (int p = 0; p < 6; p++) begin
         set_meter($urandom_range(0, 4) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 3),
                   $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 1),
                   $urandom_range(0, 255),
                   $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(0, 262143));
         fill_phase(40);
         drain();
      end

      repeat (200) @(posedge clock);
      if (level_q.size() != 0) report_mismatch("levels never produced", 0, level_q.size());
      if (n_err == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/plm_pkg.sv
hw/rtl/plm_mem.sv
hw/rtl/plm_div.sv
hw/rtl/audio_peak_level_meter_core.sv
tb/tb_audio_peak_level_meter_core.sv
